[rtl/scs_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, channel codes, lane type and result select for the sensor channel scaler.
package scs_pkg;

  // Field widths
  localparam int KIND_W   = 4;
  localparam int SAMPLE_W = 12;
  localparam int VALUE_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int NUMER_W  = 24;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 1;

  // One quotient bit per cell in the divider chain
  localparam int DIV_STEPS = VALUE_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_NUMERATOR = 1'b1;

  // Register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd5611;
  localparam logic [NUMER_W-1:0] RPM_RESET  = 24'd7680;

  // Channel codes
  localparam logic [KIND_W-1:0] KIND_FLAME     = 4'd0;
  localparam logic [KIND_W-1:0] KIND_HEX_TEMP  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_AUX_TEMP  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_CURRENT_A = 4'd3;
  localparam logic [KIND_W-1:0] KIND_CURRENT_B = 4'd4;
  localparam logic [KIND_W-1:0] KIND_PRESSURE  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_FUSE      = 4'd6;
  localparam logic [KIND_W-1:0] KIND_SUPPLY    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_FAN       = 4'd8;
  localparam logic [KIND_W-1:0] KIND_CHIP_TEMP = 4'd10;
  localparam logic [KIND_W-1:0] KIND_AVCC      = 4'd11;

  // Scaling constants
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
  localparam logic [VALUE_W-1:0]  VREF_X16   = 16'd52800;
  localparam logic [VALUE_W-1:0]  VREF_X8    = 16'd26400;
  localparam logic [VALUE_W-1:0]  T0_GAIN    = 16'd9623;
  localparam logic [VALUE_W-1:0]  T1_GAIN    = 16'd8854;
  localparam logic [VALUE_W-1:0]  CUR_GAIN   = 16'd9902;
  localparam logic [VALUE_W-1:0]  CHIP_GAIN  = 16'd14877;
  localparam logic [SAMPLE_W-1:0] P_OFFSET   = 12'd126;
  localparam logic [SAMPLE_W-1:0] T0_THRESH  = 12'd1552;
  localparam logic [SAMPLE_W-1:0] T1_THRESH  = 12'd1450;
  localparam logic [VALUE_W-1:0]  VCC_DIODE  = 16'd300;
  // Subtractions held as modulo 2^16 addends
  localparam logic [VALUE_W-1:0]  T0_ADJ     = 16'd65308;  // -228
  localparam logic [VALUE_W-1:0]  T1_ADJ     = 16'd65340;  // -196
  localparam logic [VALUE_W-1:0]  CHIP_ADJ   = 16'd65308;  // -228
  localparam logic [VALUE_W-1:0]  VALUE_MAX  = 16'hFFFF;

  // One word travelling down the cell chain
  typedef struct packed {
    logic               valid;
    logic               is_div;  // fan speed: result comes from the quotient
    logic               sat;     // zero period or quotient overflow
    logic [VALUE_W-1:0] value;   // finished result for every other channel
    logic [VALUE_W-1:0] rem;     // partial remainder, below dsr for a fan word unless sat is set
    logic [VALUE_W-1:0] dvd;     // dividend bits still to shift in, msb first
    logic [VALUE_W-1:0] quo;     // quotient bits so far
    logic [VALUE_W-1:0] dsr;     // divisor (fan period)
  } lane_t;

  // Final result of a word leaving the chain
  function automatic logic [VALUE_W-1:0] lane_result(input lane_t l);
    logic [VALUE_W-1:0] r;
    if (!l.is_div) begin
      r = l.value;
    end else if (l.sat) begin
      r = VALUE_MAX;
    end else begin
      r = l.quo;
    end
    return r;
  endfunction

endpackage

[rtl/scs_in_if.sv]
`timescale 1ns / 1ps
// Input channel: one converter word with its channel number, fuse bit and fan period.
interface scs_in_if;
  logic                              valid;
  logic                              ready;
  logic [scs_pkg::KIND_W-1:0]        kind;
  logic [scs_pkg::SAMPLE_W-1:0]      sample;
  logic                              fuse_blown;
  logic [scs_pkg::VALUE_W-1:0]       fan_period;

  modport source(output valid, kind, sample, fuse_blown, fan_period, input ready);
  modport sink(input valid, kind, sample, fuse_blown, fan_period, output ready);
endinterface

[rtl/scs_out_if.sv]
`timescale 1ns / 1ps
// Output channel: one scaled value word.
interface scs_out_if;
  logic                        valid;
  logic                        ready;
  logic [scs_pkg::VALUE_W-1:0] scaled_value;

  modport source(output valid, scaled_value, input ready);
  modport sink(input valid, scaled_value, output ready);
endinterface

[rtl/sensor_channel_scaler.sv]
`timescale 1ns / 1ps
// Top level: sensor channel scaler, front end, divider cell chain and output skid stage.
//
//  Port     Dir   Contents
//  in_ch    sink  kind, sample, fuse_blown, fan_period
//  out_ch   src   scaled_value
//  cfg_*    in    write enable, register index, data (no read-back)
//
// One word is accepted every cycle while the skid stage is empty; each result
// is offered straight from the last of 19 registers (3 front stages plus one
// cell per quotient bit of the fan divider).
// rst is synchronous and clears all valid flags and loads the register defaults.
// A stalled sink fills the single-word skid stage; the chain then freezes and
// in_ch.ready drops until that word is taken.
module sensor_channel_scaler (
  input  logic                           clk,
  input  logic                           rst,
  scs_in_if.sink                         in_ch,
  scs_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [scs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scs_pkg::CFG_W-1:0]      cfg_data
);

  localparam int N = scs_pkg::DIV_STEPS;

  logic           advance;
  logic           accept;
  scs_pkg::lane_t chain [0:N];

  assign in_ch.ready = advance;
  assign accept      = in_ch.valid && advance;

  scs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .accept     (accept),
    .kind       (in_ch.kind),
    .sample     (in_ch.sample),
    .fuse_blown (in_ch.fuse_blown),
    .fan_period (in_ch.fan_period),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .lane       (chain[0])
  );

  // Divider chain, one quotient bit per cell
  for (genvar i = 0; i < N; i++) begin : g_cell
    scs_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (advance),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  scs_skid u_skid (
    .clk     (clk),
    .rst     (rst),
    .last    (chain[N]),
    .advance (advance),
    .out     (out_ch)
  );

endmodule

[rtl/scs_front.sv]
`timescale 1ns / 1ps
// Front end: config registers, channel decode, multiply and divider set-up.
module scs_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            accept,
  input  logic [scs_pkg::KIND_W-1:0]      kind,
  input  logic [scs_pkg::SAMPLE_W-1:0]    sample,
  input  logic                            fuse_blown,
  input  logic [scs_pkg::VALUE_W-1:0]     fan_period,
  input  logic                            cfg_we,
  input  logic [scs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scs_pkg::CFG_W-1:0]       cfg_data,
  output scs_pkg::lane_t                  lane
);

  localparam int VW = scs_pkg::VALUE_W;

  typedef struct packed {
    logic          valid;
    logic          use_mul;
    logic          is_div;
    logic          sat;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic [VW-1:0] adj;
    logic [VW-1:0] byp;
    logic [VW-1:0] rem;
    logic [VW-1:0] dvd;
    logic [VW-1:0] dsr;
  } dec_t;

  typedef struct packed {
    logic          valid;
    logic          use_mul;
    logic          is_div;
    logic          sat;
    logic [VW-1:0] hi;
    logic [VW-1:0] adj;
    logic [VW-1:0] byp;
    logic [VW-1:0] rem;
    logic [VW-1:0] dvd;
    logic [VW-1:0] dsr;
  } prod_t;

  logic [scs_pkg::GAIN_W-1:0]  pressure_gain;
  logic [scs_pkg::NUMER_W-1:0] rpm_numerator;
  dec_t  dec, dec_next;
  prod_t prod;
  logic [2*VW-1:0] mul_full;
  logic [scs_pkg::SAMPLE_W-1:0] p_diff;
  logic [7:0] num_top;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_gain <= scs_pkg::GAIN_RESET;
      rpm_numerator <= scs_pkg::RPM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        scs_pkg::REG_PRESSURE_GAIN: pressure_gain <= cfg_data[scs_pkg::GAIN_W-1:0];
        scs_pkg::REG_RPM_NUMERATOR: rpm_numerator <= cfg_data[scs_pkg::NUMER_W-1:0];
        default: ;
      endcase
    end
  end

  // Channel decode: pick multiplier operands, addend or bypass value
  always_comb begin
    num_top = rpm_numerator[scs_pkg::NUMER_W-1:VW];
    p_diff  = (sample > scs_pkg::P_OFFSET) ? sample - scs_pkg::P_OFFSET : '0;

    dec_next         = '0;
    dec_next.valid   = accept;
    dec_next.byp     = VW'(sample);
    // divider set-up: quotient overflows 16 bits iff top byte >= period
    dec_next.sat     = (fan_period == '0) || (VW'(num_top) >= fan_period);
    dec_next.rem     = VW'(num_top);
    dec_next.dvd     = rpm_numerator[VW-1:0];
    dec_next.dsr     = fan_period;

    case (kind)
      scs_pkg::KIND_FLAME: begin
        dec_next.use_mul = 1'b1;
        dec_next.a       = VW'(scs_pkg::FULL_SCALE - sample);
        dec_next.b       = scs_pkg::VREF_X16;
      end
      scs_pkg::KIND_HEX_TEMP: begin
        dec_next.use_mul = (sample >= scs_pkg::T0_THRESH);
        dec_next.a       = VW'(sample);
        dec_next.b       = scs_pkg::T0_GAIN;
        dec_next.adj     = scs_pkg::T0_ADJ;
        dec_next.byp     = '0;
      end
      scs_pkg::KIND_AUX_TEMP: begin
        dec_next.use_mul = (sample >= scs_pkg::T1_THRESH);
        dec_next.a       = VW'(sample);
        dec_next.b       = scs_pkg::T1_GAIN;
        dec_next.adj     = scs_pkg::T1_ADJ;
        dec_next.byp     = '0;
      end
      scs_pkg::KIND_CURRENT_A, scs_pkg::KIND_CURRENT_B: begin
        dec_next.use_mul = 1'b1;
        dec_next.a       = {sample, 4'b0000};
        dec_next.b       = scs_pkg::CUR_GAIN;
      end
      scs_pkg::KIND_PRESSURE: begin
        dec_next.use_mul = 1'b1;
        dec_next.a       = VW'(p_diff);
        dec_next.b       = pressure_gain;
      end
      scs_pkg::KIND_FUSE: begin
        dec_next.byp     = VW'(fuse_blown);
      end
      scs_pkg::KIND_SUPPLY: begin
        // s*11 stays below 2^16 for a 12-bit sample
        dec_next.use_mul = 1'b1;
        dec_next.a       = VW'(sample) * VW'(11);
        dec_next.b       = scs_pkg::VREF_X16;
        dec_next.adj     = scs_pkg::VCC_DIODE;
      end
      scs_pkg::KIND_FAN: begin
        dec_next.is_div  = 1'b1;
      end
      scs_pkg::KIND_CHIP_TEMP: begin
        dec_next.use_mul = 1'b1;
        dec_next.a       = VW'(sample);
        dec_next.b       = scs_pkg::CHIP_GAIN;
        dec_next.adj     = scs_pkg::CHIP_ADJ;
      end
      scs_pkg::KIND_AVCC: begin
        dec_next.use_mul = 1'b1;
        dec_next.a       = VW'(sample);
        dec_next.b       = scs_pkg::VREF_X8;
      end
      default: ;
    endcase
  end

  assign mul_full = dec.a * dec.b;

  // Stage 1: decoded operands
  always_ff @(posedge clk) begin
    if (rst) begin
      dec.valid <= 1'b0;
    end else if (en) begin
      dec.valid <= dec_next.valid;
    end
    if (en) begin
      dec.use_mul <= dec_next.use_mul;
      dec.is_div  <= dec_next.is_div;
      dec.sat     <= dec_next.sat;
      dec.a       <= dec_next.a;
      dec.b       <= dec_next.b;
      dec.adj     <= dec_next.adj;
      dec.byp     <= dec_next.byp;
      dec.rem     <= dec_next.rem;
      dec.dvd     <= dec_next.dvd;
      dec.dsr     <= dec_next.dsr;
    end
  end

  // Stage 2: high half of the product
  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else if (en) begin
      prod.valid <= dec.valid;
    end
    if (en) begin
      prod.use_mul <= dec.use_mul;
      prod.is_div  <= dec.is_div;
      prod.sat     <= dec.sat;
      prod.hi      <= mul_full[2*VW-1:VW];
      prod.adj     <= dec.adj;
      prod.byp     <= dec.byp;
      prod.rem     <= dec.rem;
      prod.dvd     <= dec.dvd;
      prod.dsr     <= dec.dsr;
    end
  end

  // Stage 3: add offset, form the chain word
  always_ff @(posedge clk) begin
    if (rst) begin
      lane.valid <= 1'b0;
    end else if (en) begin
      lane.valid <= prod.valid;
    end
    if (en) begin
      lane.is_div <= prod.is_div;
      lane.sat    <= prod.sat;
      lane.value  <= prod.use_mul ? prod.hi + prod.adj : prod.byp;
      lane.rem    <= prod.rem;
      lane.dvd    <= prod.dvd;
      lane.quo    <= '0;
      lane.dsr    <= prod.dsr;
    end
  end

endmodule

[rtl/scs_div_cell.sv]
`timescale 1ns / 1ps
// Divider cell: one restoring step, one quotient bit, registered towards the next cell.
module scs_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  scs_pkg::lane_t d,
  output scs_pkg::lane_t q
);

  localparam int VW = scs_pkg::VALUE_W;

  logic [VW:0]   trial;
  logic          take;
  logic [VW:0]   diff;

  // Shift in the next dividend bit and try to subtract the divisor
  always_comb begin
    trial = {d.rem, d.dvd[VW-1]};
    diff  = trial - {1'b0, d.dsr};
    take  = (trial >= {1'b0, d.dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.is_div <= d.is_div;
      q.sat    <= d.sat;
      q.value  <= d.value;
      q.rem    <= take ? diff[VW-1:0] : trial[VW-1:0];
      q.dvd    <= {d.dvd[VW-2:0], 1'b0};
      q.quo    <= {d.quo[VW-2:0], take};
      q.dsr    <= d.dsr;
    end
  end

endmodule

[rtl/scs_skid.sv]
`timescale 1ns / 1ps
// Output skid stage: holds one finished word when the sink stalls; the chain freezes while it is full.
module scs_skid (
  input  logic           clk,
  input  logic           rst,
  input  scs_pkg::lane_t last,
  output logic           advance,
  scs_out_if.source      out
);

  logic                         full;
  logic [scs_pkg::VALUE_W-1:0]  held;
  logic [scs_pkg::VALUE_W-1:0]  last_value;

  assign last_value       = scs_pkg::lane_result(last);
  assign advance          = !full;
  assign out.valid        = full || last.valid;
  assign out.scaled_value = full ? held : last_value;

  // Catch the chain's word when the sink stalls; release once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (full) begin
      if (out.ready) full <= 1'b0;
    end else if (last.valid && !out.ready) begin
      full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!full) held <= last_value;
  end

endmodule
